// ===== hdl/spq_pkg.sv =====
// shared types and constants of the sorted priority queue
package spq_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned PRIO_W    = 8;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned ERR_W     = 2;

  // opcode values carried in the input tuser bit
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_e;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [CHAR_W-1:0] chr;
  } entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t ent;
  } cmd_t;

endpackage

// ===== hdl/spq_cell.sv =====
// one slot of the sorted row: compare, hold, take from left or right neighbor
module spq_cell (
  input  logic            clk_i,
  input  spq_pkg::cmd_t   cmd_i,
  input  logic            occupied_i,
  input  logic            tail_i,
  input  logic            left_gt_i,
  input  spq_pkg::entry_t left_entry_i,
  input  spq_pkg::entry_t right_entry_i,
  output logic            gt_o,
  output spq_pkg::entry_t entry_o
);

  spq_pkg::entry_t entry_q, entry_d;

  // held entry leaves after the new one
  assign gt_o = occupied_i && (entry_q.prio > cmd_i.ent.prio);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.enq) begin
      if (left_gt_i) begin
        entry_d = left_entry_i;
      end else if (gt_o || tail_i) begin
        entry_d = cmd_i.ent;
      end
    end else if (cmd_i.deq) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== hdl/sorted_priority_queue.sv =====
// sorted priority queue built as a row of compare-and-shift cells
// latency: a word accepted at one edge has its result in the output register after that edge
// throughput: one word per cycle unless output stalls; every cell compares and shifts in the
// same cycle; the output register is refilled while the result is being taken, so no bubble
// reset: rst_ni low clears the entry count and the output valid; slot contents are not reset
module sorted_priority_queue #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1),
  localparam int unsigned OUT_USED_W = spq_pkg::PRIO_W + spq_pkg::CHAR_W + CNT_W + 2,
  localparam int unsigned OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // slave side
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,   // in_prio [7:0], in_char [15:8]
  input  logic [0:0]            s_axis_tuser,   // opcode [0]
  // master side
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // out_prio, out_char, occupancy, is_empty,
                                                // is_full, zero fill (lowest first)
  output logic [2:0]            m_axis_tuser    // out_valid [0], error_code [2:1]
);

  // entry count and the row of cells
  logic [CNT_W-1:0] count_q, count_d;
  spq_pkg::cmd_t    cmd;
  spq_pkg::entry_t  cell_entry [DEPTH];
  logic [DEPTH-1:0] cell_gt;

  // output register
  logic                       out_vld_q;
  logic [OUT_USED_W-1:0]      out_data_q, out_data_d;
  logic [2:0]                 out_user_q, out_user_d;

  logic accept;
  logic is_enq, is_deq;
  logic full, empty;
  spq_pkg::err_e err;

  // take a new word whenever the result slot is free or being drained
  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign full   = (count_q == CNT_W'(DEPTH));
  assign empty  = (count_q == '0);
  assign is_enq = accept && (s_axis_tuser[0] == spq_pkg::OP_ENQ);
  assign is_deq = accept && (s_axis_tuser[0] == spq_pkg::OP_DEQ);

  // rejected commands leave the row untouched
  assign cmd.enq      = is_enq && !full;
  assign cmd.deq      = is_deq && !empty;
  assign cmd.ent.prio = s_axis_tdata[7:0];
  assign cmd.ent.chr  = s_axis_tdata[15:8];

  always_comb begin
    count_d = count_q;
    if (cmd.enq) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd.deq) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    err = spq_pkg::ERR_OK;
    if (is_enq && full) begin
      err = spq_pkg::ERR_FULL;
    end else if (is_deq && empty) begin
      err = spq_pkg::ERR_EMPTY;
    end
  end

  // row of cells; cell 0 is the front
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic            left_gt;
    spq_pkg::entry_t left_entry, right_entry;

    if (i == 0) begin : g_first
      assign left_gt    = 1'b0;
      assign left_entry = cmd.ent;
    end else begin : g_mid
      assign left_gt    = cell_gt[i-1];
      assign left_entry = cell_entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .occupied_i    (CNT_W'(i) < count_q),
      .tail_i        (CNT_W'(i) == count_q),
      .left_gt_i     (left_gt),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .gt_o          (cell_gt[i]),
      .entry_o       (cell_entry[i])
    );
  end

  // result word: front entry on a good dequeue, zero entry otherwise, then new count and flags
  always_comb begin
    spq_pkg::entry_t front;
    front = cmd.deq ? cell_entry[0] : '0;
    out_data_d = {(count_d == CNT_W'(DEPTH)), (count_d == '0), count_d, front.chr, front.prio};
    out_user_d = {err, cmd.deq};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_data_q);
  assign m_axis_tuser  = out_user_q;

endmodule

// ===== test/tb_sorted_priority_queue.sv =====
// testbench of the sorted priority queue: random and directed words checked against a local model
`timescale 1ns / 1ps

module tb_sorted_priority_queue;

  localparam int unsigned DEPTH      = spq_pkg::DEPTH_DEF;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned OUT_USED_W = spq_pkg::PRIO_W + spq_pkg::CHAR_W + CNT_W + 2;
  localparam int unsigned OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned WORDS_PER_PHASE = 380;

  // one word waiting for the driver
  typedef struct {
    logic       op;
    logic [7:0] prio;
    logic [7:0] chr;
    int         phase;
    bit         drain_first;  // hold it back until every result is in
  } stim_word_t;

  // one result the queue should produce
  typedef struct {
    logic             valid;
    logic [7:0]       prio;
    logic [7:0]       chr;
    logic [CNT_W-1:0] occ;
    logic             empty;
    logic             full;
    spq_pkg::err_e    err;
  } queue_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata = '0;   // in_prio [7:0], in_char [15:8]
  logic [0:0]            s_axis_tuser = '0;   // opcode [0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // out_prio, out_char, occupancy, is_empty, is_full
  logic [2:0]            m_axis_tuser;        // out_valid [0], error_code [2:1]

  stim_word_t    pending_words[$];
  queue_result_t expected_results[$];

  spq_pkg::entry_t  held_entries [DEPTH];
  int unsigned      held_count = 0;

  int unsigned send_idle_pct [3] = '{35, 84, 0};
  int unsigned recv_idle_pct [3] = '{84, 35, 0};
  int          cur_phase = 0;
  logic        in_taken = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned fail_count = 0;

  sorted_priority_queue u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch %s: got %0h, want %0h", what, got, want);
    fail_count++;
  endtask

  // sorted insert after equal priorities, front removal on dequeue
  task automatic apply_queue_op(input logic op, input logic [7:0] prio,
                                input logic [7:0] chr);
    queue_result_t r;
    int unsigned   pos;
    r = '{valid: 1'b0, prio: '0, chr: '0, occ: '0, empty: 1'b0, full: 1'b0,
          err: spq_pkg::ERR_OK};
    if (op == spq_pkg::OP_ENQ) begin
      if (held_count >= DEPTH) begin
        r.err = spq_pkg::ERR_FULL;
      end else begin
        pos = held_count;
        for (int i = int'(held_count) - 1; i >= 0; i--) begin
          if (held_entries[i].prio > prio) pos = i;
        end
        for (int i = int'(held_count); i > int'(pos); i--) held_entries[i] = held_entries[i-1];
        held_entries[pos] = '{prio: prio, chr: chr};
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.err = spq_pkg::ERR_EMPTY;
      end else begin
        r.valid = 1'b1;
        r.prio  = held_entries[0].prio;
        r.chr   = held_entries[0].chr;
        for (int i = 1; i < int'(held_count); i++) held_entries[i-1] = held_entries[i];
        held_count--;
      end
    end
    r.occ   = held_count[CNT_W-1:0];
    r.empty = (held_count == 0);
    r.full  = (held_count == DEPTH);
    expected_results.push_back(r);
  endtask

  task automatic check_result(input logic [OUT_DATA_W-1:0] got_data,
                              input logic [2:0] got_user);
    queue_result_t w;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected word", 32'(got_data), 0);
    end else begin
      w = expected_results.pop_front();
      if (got_user[0] !== w.valid)
        report_mismatch("out_valid", 32'(got_user[0]), 32'(w.valid));
      if (got_data[7:0] !== w.prio)
        report_mismatch("out_prio", 32'(got_data[7:0]), 32'(w.prio));
      if (got_data[15:8] !== w.chr)
        report_mismatch("out_char", 32'(got_data[15:8]), 32'(w.chr));
      if (got_data[16 +: CNT_W] !== w.occ)
        report_mismatch("occupancy", 32'(got_data[16 +: CNT_W]), 32'(w.occ));
      if (got_data[16+CNT_W] !== w.empty)
        report_mismatch("is_empty", 32'(got_data[16+CNT_W]), 32'(w.empty));
      if (got_data[17+CNT_W] !== w.full)
        report_mismatch("is_full", 32'(got_data[17+CNT_W]), 32'(w.full));
      if (got_user[2:1] !== w.err)
        report_mismatch("error_code", 32'(got_user[2:1]), 32'(w.err));
    end
  endtask

  task automatic add_word(input logic op, input logic [7:0] prio, input logic [7:0] chr,
                          input int phase, input bit drain_first);
    stim_word_t s;
    s = '{op: op, prio: prio, chr: chr, phase: phase, drain_first: drain_first};
    pending_words.push_back(s);
  endtask

  // driver: inputs change on the falling edge
  always @(negedge clk_i) begin
    stim_word_t s;
    if (rst_ni) begin
      // a word still waiting for its handshake stays on the bus untouched
      if (!s_axis_tvalid || in_taken) begin
        if (pending_words.size() != 0
            && !(pending_words[0].drain_first && expected_results.size() != 0)
            && $urandom_range(99) >= send_idle_pct[pending_words[0].phase]) begin
          s = pending_words.pop_front();
          cur_phase     = s.phase;
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= s.op;
          s_axis_tdata  <= {s.chr, s.prio};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct[cur_phase]);
    end
  end

  // monitor: handshakes sampled on the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_taken     <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata, m_axis_tuser);
      if (s_axis_tvalid && s_axis_tready)
        apply_queue_op(s_axis_tuser[0], s_axis_tdata[7:0], s_axis_tdata[15:8]);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned made;
    int unsigned mode;
    int unsigned burst;
    int unsigned enq_pct;
    bit          narrow;
    logic [7:0]  p;
    bit          timed_out;
    timed_out = 1'b0;

    // directed: dequeue while empty, extremes, ties, fill, enqueue while full, partial drain
    add_word(spq_pkg::OP_DEQ, 8'hFF, 8'hFF, 2, 1'b0);
    add_word(spq_pkg::OP_ENQ, 8'hFF, 8'hFF, 2, 1'b0);
    add_word(spq_pkg::OP_ENQ, 8'h00, 8'h00, 2, 1'b0);
    add_word(spq_pkg::OP_ENQ, 8'h80, 8'h11, 2, 1'b0);
    add_word(spq_pkg::OP_ENQ, 8'h80, 8'h22, 2, 1'b0);
    add_word(spq_pkg::OP_ENQ, 8'h80, 8'h33, 2, 1'b0);
    add_word(spq_pkg::OP_ENQ, 8'h00, 8'h5A, 2, 1'b0);
    add_word(spq_pkg::OP_ENQ, 8'hFF, 8'hA5, 2, 1'b0);
    for (int i = 0; i < 9; i++) add_word(spq_pkg::OP_ENQ, 8'(i * 29), 8'(8'hC0 + i), 2, 1'b0);
    add_word(spq_pkg::OP_ENQ, 8'h00, 8'hFF, 2, 1'b0);
    for (int i = 0; i < 7; i++) add_word(spq_pkg::OP_DEQ, 8'h00, 8'h00, 2, 1'b0);

    // random bursts that lean toward filling, draining or neither
    for (int ph = 0; ph < 3; ph++) begin
      made = 0;
      while (made < WORDS_PER_PHASE) begin
        mode    = $urandom_range(2);
        burst   = $urandom_range(40, 4);
        narrow  = 1'($urandom_range(1));
        enq_pct = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
        for (int k = 0; k < burst; k++) begin
          if (narrow)
            p = $urandom_range(1) ? 8'($urandom_range(3)) : 8'(252 + $urandom_range(3));
          else
            p = 8'($urandom_range(255));
          // the first word of each phase waits for the queue output to drain
          add_word(($urandom_range(99) < enq_pct) ? spq_pkg::OP_ENQ : spq_pkg::OP_DEQ,
                   p, 8'($urandom_range(255)), ph, made == 0 && k == 0);
        end
        made += burst;
      end
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (!timed_out && (pending_words.size() != 0 || s_axis_tvalid
                          || expected_results.size() != 0)) begin
      @(posedge clk_i);
      if (quiet_cycles >= QUIET_LIMIT) timed_out = 1'b1;
    end
    if (!timed_out) begin
      repeat (20) @(posedge clk_i);
      if (expected_results.size() != 0)
        report_mismatch("words never returned", 0, expected_results.size());
    end

    if (!timed_out && fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
test/tb_sorted_priority_queue.sv
